// File: design/srr_pkg.sv
// Package for the segment reorder receiver: sizes, codes, entry layout and helpers.
package srr_pkg;

    // Number of early segments that the table can hold.
    localparam int TABLE_DEPTH = 16;

    // Entry index width and the sweep counter width, which also holds TABLE_DEPTH itself.
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    // Input command codes.
    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_DELIVER = 2'd0,
        KIND_ACK     = 2'd1,
        KIND_FINAL   = 2'd2
    } t_kind;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DUP,
        S_DELIVER,
        S_SCAN,
        S_ACK
    } t_state;

    // One stored early segment.
    typedef struct packed {
        logic [31:0] seq;
        logic [11:0] len;
        logic [7:0]  tag;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Byte index plus length, saturating at the top of the index range.
    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [11:0] b);
        logic [32:0] sum;
        sum = {1'b0, a} + {21'd0, b};
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

endpackage

// File: design/segment_reorder_receiver.sv
// Top level of the segment reorder receiver: controller, valid bits and entry memory.
//
// The block takes one item at a time. An end mark or a stale segment is answered
// with its ack, which is loaded into the output register from the ACK state. An
// early segment sweeps the entry memory once to look for a duplicate start index.
// An in-order segment is delivered, then the memory is swept (freeing entries that
// have fallen behind the index) until the stored segment that starts at the new
// index is found; each such segment is delivered and starts another sweep. The
// sweeps use the single read port of the entry memory, one entry per cycle.
// Results leave through an output register, and the block waits while that
// register is stalled.
module segment_reorder_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [31:0] i_seq_index,
    input  logic [11:0] i_seg_length,
    input  logic [7:0]  i_payload_tag,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_out_tag,
    output logic [11:0] o_out_length,
    output logic [31:0] o_ack_index,
    output logic        o_dropped,
    output logic        o_last
);

    localparam srr_pkg::t_cnt CNT_DEPTH = srr_pkg::CNT_W'(srr_pkg::TABLE_DEPTH);

    // Control state.
    srr_pkg::t_state                   r_state, n_state;
    logic [31:0]                       r_exp, n_exp;
    logic [srr_pkg::TABLE_DEPTH-1:0]   r_valid, n_valid;
    srr_pkg::t_cnt                     r_rd_idx, n_rd_idx;
    logic                              r_chk, n_chk;
    srr_pkg::t_idx                     r_chk_idx, n_chk_idx;
    logic                              r_dup, n_dup;
    logic                              r_drop, n_drop;
    logic                              r_final, n_final;

    // Latched item fields, reused for the segment being delivered.
    logic [31:0]                       r_seq, n_seq;
    logic [11:0]                       r_len, n_len;
    logic [7:0]                        r_tag, n_tag;

    // Output register.
    logic                              r_o_valid, n_o_valid;
    srr_pkg::t_kind                    r_o_kind;
    logic [7:0]                        r_o_tag;
    logic [11:0]                       r_o_len;
    logic [31:0]                       r_o_ack;
    logic                              r_o_drop;
    logic                              r_o_last;

    // Result being loaded this cycle.
    logic                              emit;
    srr_pkg::t_kind                    emit_kind;
    logic [7:0]                        emit_tag;
    logic [11:0]                       emit_len;
    logic [31:0]                       emit_ack;
    logic                              emit_drop;

    // Memory port signals.
    logic                              ram_wr_en;
    srr_pkg::t_idx                     ram_wr_addr;
    srr_pkg::t_entry                   ram_wr_entry;
    logic                              ram_rd_en;
    srr_pkg::t_idx                     ram_rd_addr;
    logic [srr_pkg::ENTRY_W-1:0]       ram_rd_data;
    srr_pkg::t_entry                   rd_entry;

    logic                              in_accept;
    logic                              out_free;
    logic                              chk_live;
    logic                              free_found;
    srr_pkg::t_idx                     free_idx;

    srr_ram #(
        .WIDTH (srr_pkg::ENTRY_W),
        .DEPTH (srr_pkg::TABLE_DEPTH)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_entry),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign rd_entry   = srr_pkg::t_entry'(ram_rd_data);
    assign o_in_stall = (r_state != srr_pkg::S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_o_valid || !i_out_stall;
    assign chk_live   = r_chk && r_valid[r_chk_idx];

    // Lowest free entry of the table.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = srr_pkg::TABLE_DEPTH - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_found = 1'b1;
                free_idx   = srr_pkg::IDX_W'(i);
            end
        end
    end

    // Next state, memory accesses and result selection.
    always_comb begin
        n_state      = r_state;
        n_exp        = r_exp;
        n_valid      = r_valid;
        n_rd_idx     = r_rd_idx;
        n_chk        = r_chk;
        n_chk_idx    = r_chk_idx;
        n_dup        = r_dup;
        n_drop       = r_drop;
        n_final      = r_final;
        n_seq        = r_seq;
        n_len        = r_len;
        n_tag        = r_tag;
        emit         = 1'b0;
        emit_kind    = srr_pkg::KIND_ACK;
        emit_tag     = '0;
        emit_len     = '0;
        emit_ack     = r_exp;
        emit_drop    = 1'b0;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = free_idx;
        ram_wr_entry = '{seq: r_seq, len: r_len, tag: r_tag};
        ram_rd_en    = 1'b0;
        ram_rd_addr  = r_rd_idx[srr_pkg::IDX_W-1:0];

        case (r_state)
            srr_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_seq     = i_seq_index;
                    n_len     = i_seg_length;
                    n_tag     = i_payload_tag;
                    n_drop    = 1'b0;
                    n_dup     = 1'b0;
                    n_final   = 1'b0;
                    n_rd_idx  = '0;
                    n_chk     = 1'b0;
                    if (i_cmd == srr_pkg::CMD_END) begin
                        n_final = 1'b1;
                        n_state = srr_pkg::S_ACK;
                    end else if (i_seq_index > r_exp) begin
                        n_state = srr_pkg::S_DUP;
                    end else if (i_seq_index == r_exp) begin
                        n_exp   = srr_pkg::sat_add(r_exp, i_seg_length);
                        n_state = srr_pkg::S_DELIVER;
                    end else begin
                        n_state = srr_pkg::S_ACK;
                    end
                end
            end

            // Sweep the table for a valid entry with the same start index.
            srr_pkg::S_DUP: begin
                if (chk_live && rd_entry.seq == r_seq) begin
                    n_dup = 1'b1;
                end
                if (r_rd_idx < CNT_DEPTH) begin
                    ram_rd_en = 1'b1;
                    n_chk     = 1'b1;
                    n_chk_idx = r_rd_idx[srr_pkg::IDX_W-1:0];
                    n_rd_idx  = r_rd_idx + srr_pkg::CNT_W'(1);
                end else begin
                    n_chk = 1'b0;
                end
                if (!r_chk && r_rd_idx == CNT_DEPTH) begin
                    if (!r_dup) begin
                        if (free_found) begin
                            ram_wr_en          = 1'b1;
                            n_valid[free_idx]  = 1'b1;
                        end else begin
                            n_drop = 1'b1;
                        end
                    end
                    n_state = srr_pkg::S_ACK;
                end
            end

            // Hand out the segment held in the latched fields, then look for the next one.
            srr_pkg::S_DELIVER: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_kind = srr_pkg::KIND_DELIVER;
                    emit_tag  = r_tag;
                    emit_len  = r_len;
                    n_rd_idx  = '0;
                    n_chk     = 1'b0;
                    n_state   = srr_pkg::S_SCAN;
                end
            end

            // Free entries behind the index and stop at the first that starts at it.
            srr_pkg::S_SCAN: begin
                if (chk_live && rd_entry.seq == r_exp) begin
                    n_valid[r_chk_idx] = 1'b0;
                    n_exp   = srr_pkg::sat_add(r_exp, rd_entry.len);
                    n_len   = rd_entry.len;
                    n_tag   = rd_entry.tag;
                    n_chk   = 1'b0;
                    n_state = srr_pkg::S_DELIVER;
                end else begin
                    if (chk_live && rd_entry.seq < r_exp) begin
                        n_valid[r_chk_idx] = 1'b0;
                    end
                    if (r_rd_idx < CNT_DEPTH) begin
                        ram_rd_en = 1'b1;
                        n_chk     = 1'b1;
                        n_chk_idx = r_rd_idx[srr_pkg::IDX_W-1:0];
                        n_rd_idx  = r_rd_idx + srr_pkg::CNT_W'(1);
                    end else begin
                        n_chk = 1'b0;
                    end
                    if (!r_chk && r_rd_idx == CNT_DEPTH) begin
                        n_state = srr_pkg::S_ACK;
                    end
                end
            end

            // Closing ack or final ack for the item.
            srr_pkg::S_ACK: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_kind = r_final ? srr_pkg::KIND_FINAL : srr_pkg::KIND_ACK;
                    emit_drop = r_drop;
                    n_state   = srr_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = srr_pkg::S_IDLE;
            end
        endcase
    end

    // Output register valid: held while stalled, loaded when a result is emitted.
    always_comb begin
        if (emit) begin
            n_o_valid = 1'b1;
        end else if (r_o_valid && i_out_stall) begin
            n_o_valid = 1'b1;
        end else begin
            n_o_valid = 1'b0;
        end
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp     <= '0;
            r_valid   <= '0;
            r_rd_idx  <= '0;
            r_chk     <= 1'b0;
            r_chk_idx <= '0;
            r_dup     <= 1'b0;
            r_drop    <= 1'b0;
            r_final   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_exp     <= n_exp;
            r_valid   <= n_valid;
            r_rd_idx  <= n_rd_idx;
            r_chk     <= n_chk;
            r_chk_idx <= n_chk_idx;
            r_dup     <= n_dup;
            r_drop    <= n_drop;
            r_final   <= n_final;
            r_o_valid <= n_o_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_seq <= n_seq;
        r_len <= n_len;
        r_tag <= n_tag;
        if (emit) begin
            r_o_kind <= emit_kind;
            r_o_tag  <= emit_tag;
            r_o_len  <= emit_len;
            r_o_ack  <= emit_ack;
            r_o_drop <= emit_drop;
            r_o_last <= (emit_kind != srr_pkg::KIND_DELIVER);
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_kind       = r_o_kind;
    assign o_out_tag    = r_o_tag;
    assign o_out_length = r_o_len;
    assign o_ack_index  = r_o_ack;
    assign o_dropped    = r_o_drop;
    assign o_last       = r_o_last;

endmodule

// File: design/srr_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module srr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                             i_wr_data,
    input  logic                                         i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                             o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
